@@ sv/srgb_linear_color_blend_macros.svh @@
// Assertion macros used by the checker file.
`ifndef SRGB_LINEAR_COLOR_BLEND_MACROS_SVH
`define SRGB_LINEAR_COLOR_BLEND_MACROS_SVH

// Check a condition on every clock edge outside reset.
`define SLCB_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check a temporal property on every clock edge outside reset.
`define SLCB_ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

@@ sv/slcb_pkg.sv @@
// Constants, table types and table builders for the sRGB linear-light blender.
`timescale 1ns / 1ps
`default_nettype none

package slcb_pkg;

    localparam int LINEAR_FRAC_BITS_DEF = 20;
    localparam int WEIGHT_FRAC_BITS_DEF = 16;
    localparam int WORK_BITS            = 30;
    localparam int TAB_W                = 33;
    localparam int CODES                = 256;
    localparam int LIN_LAST             = 10;
    localparam longint unsigned DEC_OFS     = 64'd14025;
    localparam longint unsigned DEC_DEN     = 64'd269025;
    localparam longint unsigned THR_OFS     = 64'd28050;
    localparam longint unsigned THR_DEN     = 64'd538050;
    localparam longint unsigned DEC_LIN_DEN = 64'd82365;
    localparam longint unsigned THR_LIN_DEN = 64'd164730;

    typedef logic [TAB_W-1:0] lin_tab_t [CODES];

    function automatic longint unsigned qmul(input longint unsigned a,
                                             input longint unsigned b);
        return (a * b + (64'd1 << (WORK_BITS - 1))) >> WORK_BITS;
    endfunction

    function automatic longint unsigned work_to_lin(input longint unsigned v,
                                                    input int lfb);
        if (lfb >= WORK_BITS)
            return v << (lfb - WORK_BITS);
        return (v + (64'd1 << (WORK_BITS - lfb - 1))) >> (WORK_BITS - lfb);
    endfunction

    // u^2.4 as (u^2) * (u^2)^(1/5), u in Q30
    function automatic longint unsigned pow_curve(input longint unsigned u,
                                                  input int lfb);
        longint unsigned s;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned m2;
        longint unsigned p5;
        s  = qmul(u, u);
        lo = 64'd0;
        hi = 64'd1 << WORK_BITS;
        while (lo < hi) begin
            mid = (lo + hi + 64'd1) >> 1;
            m2  = qmul(mid, mid);
            p5  = qmul(qmul(m2, m2), mid);
            if (p5 <= s)
                lo = mid;
            else
                hi = mid - 64'd1;
        end
        return work_to_lin(qmul(s, lo), lfb);
    endfunction

    function automatic lin_tab_t build_dec_tab(input int lfb);
        lin_tab_t        tab;
        longint unsigned num;
        longint unsigned u;
        for (int c = 0; c < CODES; c++) begin
            if (c <= LIN_LAST) begin
                num    = longint'(c) * 64'd25;
                tab[c] = TAB_W'(((num << lfb) + DEC_LIN_DEN / 2) / DEC_LIN_DEN);
            end else begin
                num    = 64'd1000 * longint'(c) + DEC_OFS;
                u      = ((num << WORK_BITS) + DEC_DEN / 2) / DEC_DEN;
                tab[c] = TAB_W'(pow_curve(u, lfb));
            end
        end
        return tab;
    endfunction

    function automatic lin_tab_t build_thr_tab(input int lfb);
        lin_tab_t        tab;
        longint unsigned odd;
        longint unsigned u;
        tab[0] = '0;
        for (int k = 1; k < CODES; k++) begin
            odd = 64'd2 * longint'(k) - 64'd1;
            if (k <= LIN_LAST) begin
                tab[k] = TAB_W'((((odd * 64'd25) << lfb) + THR_LIN_DEN / 2)
                                / THR_LIN_DEN);
            end else begin
                u      = (((64'd1000 * odd + THR_OFS) << WORK_BITS) + THR_DEN / 2)
                         / THR_DEN;
                tab[k] = TAB_W'(pow_curve(u, lfb));
            end
        end
        return tab;
    endfunction

endpackage

`default_nettype wire

@@ sv/srgb_linear_color_blend.sv @@
// Pipelined sRGB blender: decode to linear light, mix by weight, re-encode.
// Regs: input, decode, product, mix, threshold, output; done strobes with output.
// Throughput: one request per cycle in the six-register pipe; busy is tied low.
// The receiver cannot stall; every result appears for exactly one cycle.
// Reset (rst_n low, asynchronous) drops all requests in flight.
`timescale 1ns / 1ps
`default_nettype none

module srgb_linear_color_blend
    import slcb_pkg::*;
#(
    parameter int LINEAR_FRAC_BITS = LINEAR_FRAC_BITS_DEF,
    parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_BITS_DEF
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [23:0]                 color_from,
    input  wire logic [23:0]                 color_to,
    input  wire logic [WEIGHT_FRAC_BITS:0]   blend_weight,
    output logic                             done,
    output logic [23:0]                      blended_color
);

    localparam int LIN_W  = LINEAR_FRAC_BITS + 1;
    localparam int WGT_W  = WEIGHT_FRAC_BITS + 1;
    localparam int PROD_W = LIN_W + WGT_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int NCH    = 3;
    localparam int STAGES = 5;
    localparam int NTHR   = CODES - 1;

    localparam lin_tab_t DEC_TAB = build_dec_tab(LINEAR_FRAC_BITS);
    localparam lin_tab_t THR_TAB = build_thr_tab(LINEAR_FRAC_BITS);

    localparam logic [WGT_W-1:0] W_ONE  = WGT_W'(1) << WEIGHT_FRAC_BITS;
    localparam logic [SUM_W-1:0] W_HALF = SUM_W'(1) << (WEIGHT_FRAC_BITS - 1);

    logic [STAGES-1:0] vld_reg;
    logic              done_reg;

    logic [23:0]       from_reg;
    logic [23:0]       to_reg;
    logic [WGT_W-1:0]  wgt_reg;

    logic [LIN_W-1:0]  a_reg   [NCH];
    logic [LIN_W-1:0]  b_reg   [NCH];
    logic [WGT_W-1:0]  wsat_reg;

    logic [PROD_W-1:0] pa_reg  [NCH];
    logic [PROD_W-1:0] pb_reg  [NCH];

    logic [LIN_W-1:0]  mix_reg [NCH];
    logic [LIN_W-1:0]  mix_next [NCH];

    logic [NTHR-1:0]   therm_reg  [NCH];
    logic [NTHR-1:0]   therm_next [NCH];

    logic [23:0]       color_reg;
    logic [23:0]       color_next;

    logic [WGT_W-1:0]  wsat_next;
    logic [WGT_W-1:0]  winv;

    assign busy          = 1'b0;
    assign done          = done_reg;
    assign blended_color = color_reg;

    // advance the valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= {vld_reg[STAGES-2:0], start & ~busy};
            done_reg <= vld_reg[STAGES-1];
        end
    end

    assign wsat_next = (wgt_reg > W_ONE) ? W_ONE : wgt_reg;
    assign winv      = W_ONE - wsat_reg;

    always_comb
    begin
        for (int ch = 0; ch < NCH; ch++)
        begin
            mix_next[ch] = LIN_W'((SUM_W'(pa_reg[ch]) + SUM_W'(pb_reg[ch]) + W_HALF)
                                  >> WEIGHT_FRAC_BITS);
        end
    end

    always_comb
    begin
        for (int ch = 0; ch < NCH; ch++)
        begin
            for (int k = 1; k < CODES; k++)
            begin
                therm_next[ch][k-1] = (mix_reg[ch] >= THR_TAB[k][LIN_W-1:0]);
            end
        end
    end

    // walk the threshold ladder one bit per step
    always_comb
    begin
        logic [7:0] code;
        logic [7:0] probe;
        color_next = '0;
        for (int ch = 0; ch < NCH; ch++)
        begin
            code = '0;
            for (int b = 7; b >= 0; b--)
            begin
                probe = code | (8'd1 << b);
                if (therm_reg[ch][probe - 8'd1])
                    code = probe;
            end
            color_next[8*ch +: 8] = code;
        end
    end

    always_ff @(posedge clk)
    begin
        from_reg <= color_from;
        to_reg   <= color_to;
        wgt_reg  <= blend_weight;
        wsat_reg <= wsat_next;
        for (int ch = 0; ch < NCH; ch++)
        begin
            a_reg[ch]     <= DEC_TAB[from_reg[8*ch +: 8]][LIN_W-1:0];
            b_reg[ch]     <= DEC_TAB[to_reg[8*ch +: 8]][LIN_W-1:0];
            pa_reg[ch]    <= PROD_W'(a_reg[ch]) * PROD_W'(winv);
            pb_reg[ch]    <= PROD_W'(b_reg[ch]) * PROD_W'(wsat_reg);
            mix_reg[ch]   <= mix_next[ch];
            therm_reg[ch] <= therm_next[ch];
        end
        color_reg <= color_next;
    end

endmodule

`default_nettype wire

@@ sv/slcb_checker.sv @@
// Port-level checker for the sRGB linear-light blender, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "srgb_linear_color_blend_macros.svh"

module slcb_checker
#(
    parameter int WEIGHT_FRAC_BITS = 16
)
(
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      start,
    input wire logic                      busy,
    input wire logic [23:0]               color_from,
    input wire logic [23:0]               color_to,
    input wire logic [WEIGHT_FRAC_BITS:0] blend_weight,
    input wire logic                      done,
    input wire logic [23:0]               blended_color
);

    localparam int LAT = 6;

    `SLCB_ASSERT_ALWAYS(a_never_busy, clk, rst_n, !busy, "busy raised")

    `SLCB_ASSERT_PROP(a_done_follows, clk, rst_n, (start && !busy) |-> ##LAT done, "request lost")

    `SLCB_ASSERT_PROP(a_done_has_req, clk, rst_n, done |-> $past(start && !busy, LAT), "result without request")

    `SLCB_ASSERT_PROP(a_same_color, clk, rst_n, (start && !busy && color_from == color_to && blend_weight == '0) |-> ##LAT (blended_color == $past(color_from, LAT)), "identity blend altered color")

endmodule

bind srgb_linear_color_blend slcb_checker #(
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
) u_slcb_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .color_from    (color_from),
    .color_to      (color_to),
    .blend_weight  (blend_weight),
    .done          (done),
    .blended_color (blended_color)
);

`default_nettype wire
